/* src/i2c_target_command_fifo_front_core_defines.svh */
// assertion helpers for the command front end
// the clock is clk and the reset is rst in every file that uses them
`ifndef I2C_TARGET_COMMAND_FIFO_FRONT_CORE_DEFINES_SVH
`define I2C_TARGET_COMMAND_FIFO_FRONT_CORE_DEFINES_SVH

`ifndef SYNTH

// property that must hold at every edge out of reset
`define I2CTCF_CHK_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("i2ctcf check failed");

// implication checked at every edge out of reset
`define I2CTCF_CHK_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2ctcf check failed");

`else

`define I2CTCF_CHK_ALWAYS(label, expr)

`define I2CTCF_CHK_IMPLY(label, ante, cons)

`endif

`endif

/* src/i2ctcf_pkg.sv */
`timescale 1ns / 1ps

package i2ctcf_pkg;

  // event codes
  localparam logic [2:0] OP_ADDR_MATCH = 3'd0;
  localparam logic [2:0] OP_STOP       = 3'd1;
  localparam logic [2:0] OP_WRITE_BYTE = 3'd2;
  localparam logic [2:0] OP_READ_BYTE  = 3'd3;
  localparam logic [2:0] OP_HOST_DONE  = 3'd4;
  localparam logic [2:0] OP_HOST_PUSH  = 3'd5;
  localparam logic [2:0] OP_HOST_POP   = 3'd6;
  localparam logic [2:0] OP_ENABLE_CTL = 3'd7;

  // received byte counter, saturating
  localparam int unsigned COUNT_W = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
  localparam logic [COUNT_W-1:0] ADDR_BYTES = 6'd2;

  // byte sent on a read with nothing queued or while stopped
  localparam logic [7:0] TX_EMPTY_BYTE = 8'hFF;

  typedef struct packed {
    logic [2:0] opcode;
    logic       is_restart;
    logic       is_read;
    logic [7:0] data;
  } evt_t;

  typedef struct packed {
    logic               ack;
    logic [7:0]         tx_byte;
    logic               cmd_valid;
    logic [7:0]         cmd_reg_high;
    logic [7:0]         cmd_reg_low;
    logic [COUNT_W-1:0] cmd_len;
    logic [7:0]         host_byte;
    logic               host_byte_valid;
    logic               push_accepted;
    logic               busy_flag;
    logic               enabled_flag;
  } res_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* src/i2ctcf_fifo.sv */
`timescale 1ns / 1ps

module i2ctcf_fifo #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  i2ctcf_pkg::fifo_ctrl_t ctrl,
  input  logic [7:0]             wdata,
  output logic [7:0]             rdata,
  output i2ctcf_pkg::fifo_stat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (ctrl.clear) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (ctrl.push) begin
        tail <= (tail == LAST) ? '0 : tail + PTR_W'(1);
      end
      if (ctrl.pop) begin
        head <= (head == LAST) ? '0 : head + PTR_W'(1);
      end
      if (ctrl.push && !ctrl.pop) begin
        count <= count + CNT_W'(1);
      end else if (ctrl.pop && !ctrl.push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // storage, read data registered on a pop
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[tail] <= wdata;
    end
    if (ctrl.pop) begin
      rdata <= mem[head];
    end
  end

  assign stat.full  = (count == FULL_COUNT);
  assign stat.empty = (count == '0);

endmodule

/* src/i2c_target_command_fifo_front_core.sv */
`timescale 1ns / 1ps
// channel | direction | handshake        | payload
// evt     | in        | evt_valid/stall  | i2ctcf_pkg::evt_t, one bus or host event
// res     | out       | res_valid/stall  | i2ctcf_pkg::res_t, one result per item
//
// one item a cycle while evt_stall is low: decisions and state updates happen at the accepting edge
// the queue read data is registered there; a result passes the stage register,
// then the output register
// rst is synchronous: block stopped, not busy, both queues empty
// a stall on res holds the output register; the stage register takes one more
// item, after which evt_stall rises until the output drains
`include "i2c_target_command_fifo_front_core_defines.svh"

module i2c_target_command_fifo_front_core #(
  parameter int unsigned IN_DEPTH  = 32,
  parameter int unsigned OUT_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             evt_valid,
  output logic             evt_stall,
  input  i2ctcf_pkg::evt_t evt,
  output logic             res_valid,
  input  logic             res_stall,
  output i2ctcf_pkg::res_t res
);

  // stage register: the result minus the queue bytes, plus how to fill them
  typedef struct packed {
    i2ctcf_pkg::res_t res;
    logic             tx_hit;
    logic             tx_empty;
  } stage_t;

  // architectural state
  logic                           enabled;
  logic                           busy;
  logic [i2ctcf_pkg::COUNT_W-1:0] byte_count;
  logic [7:0]                     addr_high;
  logic [7:0]                     addr_low;

  logic                           enabled_next;
  logic                           busy_next;
  logic [i2ctcf_pkg::COUNT_W-1:0] byte_count_next;
  logic [7:0]                     addr_high_next;
  logic [7:0]                     addr_low_next;

  // queues
  i2ctcf_pkg::fifo_ctrl_t in_ctrl;
  i2ctcf_pkg::fifo_ctrl_t out_ctrl;
  i2ctcf_pkg::fifo_stat_t in_stat;
  i2ctcf_pkg::fifo_stat_t out_stat;
  logic [7:0]             in_rdata;
  logic [7:0]             out_rdata;

  // pipeline
  logic   accept;
  logic   stage_valid;
  stage_t stage;
  stage_t stage_next;
  logic   out_load;
  i2ctcf_pkg::res_t res_fill;

  logic                           issue;
  logic [i2ctcf_pkg::COUNT_W-1:0] count_inc;
  logic [i2ctcf_pkg::COUNT_W-1:0] cmd_len_calc;

  // output register frees when empty or taken this cycle
  assign out_load  = stage_valid && (!res_valid || !res_stall);
  assign evt_stall = stage_valid && !out_load;
  assign accept    = evt_valid && !evt_stall;

  // saturating count of written bytes, and length past the two address bytes
  assign count_inc = (byte_count == i2ctcf_pkg::COUNT_MAX) ? byte_count
                   : byte_count + i2ctcf_pkg::COUNT_W'(1);
  assign cmd_len_calc = (byte_count > i2ctcf_pkg::ADDR_BYTES)
                      ? byte_count - i2ctcf_pkg::ADDR_BYTES : '0;

  // event decode
  always_comb begin
    enabled_next    = enabled;
    busy_next       = busy;
    byte_count_next = byte_count;
    addr_high_next  = addr_high;
    addr_low_next   = addr_low;
    in_ctrl         = '0;
    out_ctrl        = '0;
    issue           = 1'b0;
    stage_next      = '0;

    case (evt.opcode)
      i2ctcf_pkg::OP_ADDR_MATCH: begin
        // nack while busy or stopped
        if (enabled && !busy) begin
          stage_next.res.ack = 1'b1;
          if (evt.is_restart && !evt.is_read) begin
            issue = 1'b1;
          end else begin
            byte_count_next = '0;
          end
        end
      end
      i2ctcf_pkg::OP_STOP: begin
        if (enabled) begin
          if (busy) begin
            byte_count_next = '0;
          end else begin
            issue = 1'b1;
          end
        end
      end
      i2ctcf_pkg::OP_WRITE_BYTE: begin
        if (enabled) begin
          if (count_inc == i2ctcf_pkg::COUNT_W'(1)) begin
            addr_high_next     = evt.data;
            byte_count_next    = count_inc;
            stage_next.res.ack = 1'b1;
          end else if (count_inc == i2ctcf_pkg::ADDR_BYTES) begin
            addr_low_next      = evt.data;
            byte_count_next    = count_inc;
            stage_next.res.ack = 1'b1;
          end else if (!in_stat.full) begin
            // data byte, nacked and not counted when the queue is full
            in_ctrl.push       = 1'b1;
            byte_count_next    = count_inc;
            stage_next.res.ack = 1'b1;
          end
        end
      end
      i2ctcf_pkg::OP_READ_BYTE: begin
        if (enabled && !out_stat.empty) begin
          out_ctrl.pop      = 1'b1;
          stage_next.tx_hit = 1'b1;
        end else begin
          stage_next.tx_empty = 1'b1;
        end
      end
      i2ctcf_pkg::OP_HOST_DONE: begin
        if (enabled && busy) begin
          busy_next = 1'b0;
        end
      end
      i2ctcf_pkg::OP_HOST_PUSH: begin
        if (!out_stat.full) begin
          out_ctrl.push                = 1'b1;
          stage_next.res.push_accepted = 1'b1;
        end
      end
      i2ctcf_pkg::OP_HOST_POP: begin
        if (!in_stat.empty) begin
          in_ctrl.pop                    = 1'b1;
          stage_next.res.host_byte_valid = 1'b1;
        end
      end
      i2ctcf_pkg::OP_ENABLE_CTL: begin
        if (evt.data[0]) begin
          // start from stopped: fresh queues and counters
          if (!enabled) begin
            enabled_next    = 1'b1;
            busy_next       = 1'b0;
            byte_count_next = '0;
            in_ctrl.clear   = 1'b1;
            out_ctrl.clear  = 1'b1;
          end
        end else begin
          // stop keeps queue contents
          enabled_next = 1'b0;
          busy_next    = 1'b0;
        end
      end
      default: begin
        enabled_next = enabled;
      end
    endcase

    // command report on stop or restart for a write
    if (issue) begin
      stage_next.res.cmd_valid    = 1'b1;
      stage_next.res.cmd_reg_high = addr_high;
      stage_next.res.cmd_reg_low  = addr_low;
      stage_next.res.cmd_len      = cmd_len_calc;
      byte_count_next             = '0;
      // zero length is a read command: flush replies and wait for the host
      if (cmd_len_calc == '0) begin
        out_ctrl.clear = 1'b1;
        busy_next      = 1'b1;
      end
    end

    stage_next.res.busy_flag    = busy_next;
    stage_next.res.enabled_flag = enabled_next;

    // queue actions only for an accepted item
    in_ctrl  = accept ? in_ctrl  : '0;
    out_ctrl = accept ? out_ctrl : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled    <= 1'b0;
      busy       <= 1'b0;
      byte_count <= '0;
      addr_high  <= '0;
      addr_low   <= '0;
    end else if (accept) begin
      enabled    <= enabled_next;
      busy       <= busy_next;
      byte_count <= byte_count_next;
      addr_high  <= addr_high_next;
      addr_low   <= addr_low_next;
    end
  end

  // queue from bus writes to host pops
  i2ctcf_fifo #(
    .DEPTH (IN_DEPTH)
  ) u_in_fifo (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (in_ctrl),
    .wdata (evt.data),
    .rdata (in_rdata),
    .stat  (in_stat)
  );

  // queue from host pushes to bus reads
  i2ctcf_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (out_ctrl),
    .wdata (evt.data),
    .rdata (out_rdata),
    .stat  (out_stat)
  );

  // stage register, sits alongside the registered queue read data
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (out_load) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= stage_next;
    end
  end

  // merge queue bytes into the result
  always_comb begin
    res_fill = stage.res;
    if (stage.tx_hit) begin
      res_fill.tx_byte = out_rdata;
    end else if (stage.tx_empty) begin
      res_fill.tx_byte = i2ctcf_pkg::TX_EMPTY_BYTE;
    end else begin
      res_fill.tx_byte = '0;
    end
    res_fill.host_byte = stage.res.host_byte_valid ? in_rdata : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res <= res_fill;
    end
  end

  // busy only ever set while running
  `I2CTCF_CHK_ALWAYS(a_busy_needs_enable, !busy || enabled)
  // a result carries at most one of: bus read, host push, host pop
  `I2CTCF_CHK_IMPLY(a_one_action, stage_valid, $onehot0({stage.tx_hit || stage.tx_empty, stage.res.push_accepted, stage.res.host_byte_valid}))
  // a read command leaves the block busy, a write command leaves it free
  `I2CTCF_CHK_IMPLY(a_cmd_busy, stage_valid && stage.res.cmd_valid, stage.res.busy_flag == (stage.res.cmd_len == '0))
  // starting the block empties both queues
  `I2CTCF_CHK_IMPLY(a_start_empties, $rose(enabled), in_stat.empty && out_stat.empty)

endmodule

/* tb/i2c_target_command_fifo_front_core_tb.sv */
`timescale 1ns / 1ps

module i2c_target_command_fifo_front_core_tb;

  localparam int RX_DEPTH     = 32;
  localparam int TX_DEPTH     = 32;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 40;

  // how a controller write transfer ends
  typedef enum logic [1:0] {
    END_STOP,
    END_RESTART_WRITE,
    END_READBACK
  } xfer_end_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic evt_valid = 1'b0;
  logic evt_stall;
  i2ctcf_pkg::evt_t evt = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  i2ctcf_pkg::res_t res;

  // predicted target state, as it stands after every accepted item
  logic                           tgt_enabled  = 1'b0;
  logic                           tgt_busy     = 1'b0;
  logic [i2ctcf_pkg::COUNT_W-1:0] tgt_count    = '0;
  logic [7:0]                     tgt_reg_high = 8'h00;
  logic [7:0]                     tgt_reg_low  = 8'h00;
  logic [7:0]                     rx_fifo[$];
  logic [7:0]                     tx_fifo[$];

  // responses still owed by the block, oldest first
  i2ctcf_pkg::res_t pending_responses[$];

  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct       = 0;
  int holdoff_left    = 0;
  int cycle_count     = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int commands_seen   = 0;
  int mismatches      = 0;

  always #6 clk = ~clk;

  i2c_target_command_fifo_front_core #(
    .IN_DEPTH  (RX_DEPTH),
    .OUT_DEPTH (TX_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // works out the response to one item and moves the predicted state on
  function automatic i2ctcf_pkg::res_t predict_response(input i2ctcf_pkg::evt_t e);
    i2ctcf_pkg::res_t r;
    logic issue;
    logic [i2ctcf_pkg::COUNT_W-1:0] next_count;
    logic [i2ctcf_pkg::COUNT_W-1:0] len;
    r = '0;
    issue = 1'b0;
    case (e.opcode)
      i2ctcf_pkg::OP_ADDR_MATCH: begin
        // refused while stopped or busy; a restart for a write closes the command
        if (tgt_enabled && !tgt_busy) begin
          r.ack = 1'b1;
          if (e.is_restart && !e.is_read) issue = 1'b1;
          else tgt_count = '0;
        end
      end
      i2ctcf_pkg::OP_STOP: begin
        if (tgt_enabled) begin
          if (tgt_busy) tgt_count = '0;
          else issue = 1'b1;
        end
      end
      i2ctcf_pkg::OP_WRITE_BYTE: begin
        if (tgt_enabled) begin
          // count sticks at its maximum on a long write
          next_count = (tgt_count < i2ctcf_pkg::COUNT_MAX)
                     ? tgt_count + i2ctcf_pkg::COUNT_W'(1) : i2ctcf_pkg::COUNT_MAX;
          if (next_count == 6'd1) begin
            tgt_reg_high = e.data;
            tgt_count = next_count;
            r.ack = 1'b1;
          end else if (next_count == i2ctcf_pkg::ADDR_BYTES) begin
            tgt_reg_low = e.data;
            tgt_count = next_count;
            r.ack = 1'b1;
          end else if (rx_fifo.size() < RX_DEPTH) begin
            rx_fifo.push_back(e.data);
            tgt_count = next_count;
            r.ack = 1'b1;
          end
          // full queue: nack, byte not counted
        end
      end
      i2ctcf_pkg::OP_READ_BYTE: begin
        if (tgt_enabled && tx_fifo.size() != 0)
          r.tx_byte = tx_fifo.pop_front();
        else
          r.tx_byte = i2ctcf_pkg::TX_EMPTY_BYTE;
      end
      i2ctcf_pkg::OP_HOST_DONE: begin
        if (tgt_enabled) tgt_busy = 1'b0;
      end
      i2ctcf_pkg::OP_HOST_PUSH: begin
        if (tx_fifo.size() < TX_DEPTH) begin
          tx_fifo.push_back(e.data);
          r.push_accepted = 1'b1;
        end
      end
      i2ctcf_pkg::OP_HOST_POP: begin
        if (rx_fifo.size() != 0) begin
          r.host_byte = rx_fifo.pop_front();
          r.host_byte_valid = 1'b1;
        end
      end
      i2ctcf_pkg::OP_ENABLE_CTL: begin
        if (e.data[0]) begin
          // a start from stopped empties both queues; a repeated start is ignored
          if (!tgt_enabled) begin
            tgt_enabled = 1'b1;
            tgt_busy = 1'b0;
            tgt_count = '0;
            rx_fifo.delete();
            tx_fifo.delete();
          end
        end else begin
          tgt_enabled = 1'b0;
          tgt_busy = 1'b0;
        end
      end
      default: ;
    endcase
    if (issue) begin
      // a lone register byte gives length zero, like no data at all
      len = (tgt_count > i2ctcf_pkg::ADDR_BYTES) ? tgt_count - i2ctcf_pkg::ADDR_BYTES : '0;
      r.cmd_valid = 1'b1;
      r.cmd_reg_high = tgt_reg_high;
      r.cmd_reg_low = tgt_reg_low;
      r.cmd_len = len;
      tgt_count = '0;
      if (len == '0) begin
        tx_fifo.delete();
        tgt_busy = 1'b1;
      end
      commands_seen++;
    end
    r.busy_flag = tgt_busy;
    r.enabled_flag = tgt_enabled;
    return r;
  endfunction

  // offers one item, with random idle cycles first, and records its response once taken
  task automatic send_event(input logic [2:0] op, input logic restart, input logic rd,
                            input logic [7:0] d);
    i2ctcf_pkg::evt_t e;
    e.opcode = op;
    e.is_restart = restart;
    e.is_read = rd;
    e.data = d;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      evt_valid <= 1'b0;
      @(posedge clk);
    end
    evt <= e;
    evt_valid <= 1'b1;
    @(posedge clk);
    while (evt_stall) @(posedge clk);
    pending_responses.push_back(predict_response(e));
    items_sent++;
  endtask

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
    end
  endtask

  task automatic check_response(input i2ctcf_pkg::res_t got);
    i2ctcf_pkg::res_t want;
    results_checked++;
    if (pending_responses.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: response %h arrived with none expected", $time, got);
    end else begin
      want = pending_responses.pop_front();
      check_field("ack", {7'd0, want.ack}, {7'd0, got.ack});
      check_field("tx_byte", want.tx_byte, got.tx_byte);
      check_field("cmd_valid", {7'd0, want.cmd_valid}, {7'd0, got.cmd_valid});
      check_field("cmd_reg_high", want.cmd_reg_high, got.cmd_reg_high);
      check_field("cmd_reg_low", want.cmd_reg_low, got.cmd_reg_low);
      check_field("cmd_len", {2'd0, want.cmd_len}, {2'd0, got.cmd_len});
      check_field("host_byte", want.host_byte, got.host_byte);
      check_field("host_byte_valid", {7'd0, want.host_byte_valid},
                  {7'd0, got.host_byte_valid});
      check_field("push_accepted", {7'd0, want.push_accepted}, {7'd0, got.push_accepted});
      check_field("busy_flag", {7'd0, want.busy_flag}, {7'd0, got.busy_flag});
      check_field("enabled_flag", {7'd0, want.enabled_flag}, {7'd0, got.enabled_flag});
    end
  endtask

  // result side: check each accepted item, then pick the stall for the next edge
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && !res_stall) check_response(res);
      if (holdoff_left > 0) begin
        // long hold-off, counted down here
        holdoff_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
    end
  end

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached, %0d responses outstanding", $time,
               pending_responses.size());
      $display("FAILURE");
      $finish;
    end
  end

  // controller reads back: address match for read, some reads, stop
  task automatic bus_read(input logic restart, input int nreads);
    send_event(i2ctcf_pkg::OP_ADDR_MATCH, restart, 1'b1, 8'($urandom));
    repeat (nreads) send_event(i2ctcf_pkg::OP_READ_BYTE, 1'b0, 1'b0, 8'($urandom));
    send_event(i2ctcf_pkg::OP_STOP, 1'b0, 1'b0, 8'($urandom));
  endtask

  // controller write: address match, bytes with host pops mixed in, then the chosen end
  task automatic bus_write(input int nbytes, input xfer_end_t tail, input int unsigned pop_pct);
    send_event(i2ctcf_pkg::OP_ADDR_MATCH, 1'b0, 1'b0, 8'($urandom));
    for (int i = 0; i < nbytes; i++) begin
      send_event(i2ctcf_pkg::OP_WRITE_BYTE, 1'b0, 1'b0, 8'($urandom));
      if ($urandom_range(99) < pop_pct)
        send_event(i2ctcf_pkg::OP_HOST_POP, 1'b0, 1'b0, 8'($urandom));
    end
    case (tail)
      END_STOP:          send_event(i2ctcf_pkg::OP_STOP, 1'b0, 1'b0, 8'($urandom));
      END_RESTART_WRITE: send_event(i2ctcf_pkg::OP_ADDR_MATCH, 1'b1, 1'b0, 8'($urandom));
      default:           bus_read(1'b1, $urandom_range(1, 6));
    endcase
  endtask

  task automatic test_disabled_block();
    // stopped after reset: bus side refused, host side still moves the queues
    send_event(i2ctcf_pkg::OP_ADDR_MATCH, 1'b0, 1'b0, 8'h00);
    send_event(i2ctcf_pkg::OP_WRITE_BYTE, 1'b0, 1'b0, 8'hFF);
    send_event(i2ctcf_pkg::OP_STOP, 1'b0, 1'b0, 8'h00);
    send_event(i2ctcf_pkg::OP_READ_BYTE, 1'b0, 1'b0, 8'h00);
    send_event(i2ctcf_pkg::OP_HOST_DONE, 1'b0, 1'b0, 8'h00);
    send_event(i2ctcf_pkg::OP_HOST_PUSH, 1'b0, 1'b0, 8'hA5);
    send_event(i2ctcf_pkg::OP_READ_BYTE, 1'b0, 1'b0, 8'h00);   // still idle byte while stopped
    send_event(i2ctcf_pkg::OP_HOST_POP, 1'b0, 1'b0, 8'h00);    // nothing to pop
    send_event(i2ctcf_pkg::OP_ENABLE_CTL, 1'b0, 1'b0, 8'hFE);  // bit 0 clear, stays stopped
    send_event(i2ctcf_pkg::OP_ENABLE_CTL, 1'b0, 1'b0, 8'h01);  // start, queued byte dropped
    send_event(i2ctcf_pkg::OP_ENABLE_CTL, 1'b1, 1'b1, 8'hFF);  // already running
    send_event(i2ctcf_pkg::OP_READ_BYTE, 1'b0, 1'b0, 8'h00);
  endtask

  task automatic test_command_cases();
    // plain write with two data bytes
    send_event(i2ctcf_pkg::OP_ADDR_MATCH, 1'b0, 1'b0, 8'h00);
    send_event(i2ctcf_pkg::OP_WRITE_BYTE, 1'b0, 1'b0, 8'h00);
    send_event(i2ctcf_pkg::OP_WRITE_BYTE, 1'b0, 1'b0, 8'hFF);
    send_event(i2ctcf_pkg::OP_WRITE_BYTE, 1'b0, 1'b0, 8'h5A);
    send_event(i2ctcf_pkg::OP_WRITE_BYTE, 1'b0, 1'b0, 8'hA5);
    send_event(i2ctcf_pkg::OP_STOP, 1'b0, 1'b0, 8'h00);
    // lone register byte: length zero, goes busy
    send_event(i2ctcf_pkg::OP_ADDR_MATCH, 1'b0, 1'b0, 8'h00);
    send_event(i2ctcf_pkg::OP_WRITE_BYTE, 1'b0, 1'b0, 8'h81);
    send_event(i2ctcf_pkg::OP_STOP, 1'b0, 1'b0, 8'h00);
    // busy: match refused, reads served, stop issues nothing
    send_event(i2ctcf_pkg::OP_ADDR_MATCH, 1'b1, 1'b0, 8'h00);
    send_event(i2ctcf_pkg::OP_HOST_PUSH, 1'b0, 1'b0, 8'h3C);
    send_event(i2ctcf_pkg::OP_READ_BYTE, 1'b0, 1'b0, 8'h00);
    send_event(i2ctcf_pkg::OP_READ_BYTE, 1'b0, 1'b0, 8'h00);
    send_event(i2ctcf_pkg::OP_STOP, 1'b0, 1'b0, 8'h00);
    send_event(i2ctcf_pkg::OP_HOST_DONE, 1'b0, 1'b0, 8'h00);
    send_event(i2ctcf_pkg::OP_HOST_DONE, 1'b0, 1'b0, 8'h00);   // not busy any more
    // restart for a write closes the command
    send_event(i2ctcf_pkg::OP_ADDR_MATCH, 1'b0, 1'b0, 8'h00);
    send_event(i2ctcf_pkg::OP_WRITE_BYTE, 1'b0, 1'b0, 8'h12);
    send_event(i2ctcf_pkg::OP_WRITE_BYTE, 1'b0, 1'b0, 8'h34);
    send_event(i2ctcf_pkg::OP_ADDR_MATCH, 1'b1, 1'b0, 8'h00);
    // stopping clears busy and keeps the queues; starting again empties them
    send_event(i2ctcf_pkg::OP_ENABLE_CTL, 1'b0, 1'b0, 8'h00);
    send_event(i2ctcf_pkg::OP_ENABLE_CTL, 1'b0, 1'b0, 8'h01);
    // restart for a read only restarts the count
    send_event(i2ctcf_pkg::OP_ADDR_MATCH, 1'b1, 1'b1, 8'h00);
    send_event(i2ctcf_pkg::OP_STOP, 1'b0, 1'b0, 8'h00);
    send_event(i2ctcf_pkg::OP_HOST_DONE, 1'b0, 1'b0, 8'h00);
  endtask

  task automatic test_queue_limits();
    // two register bytes, a full input queue and one refused byte
    bus_write(RX_DEPTH + 3, END_STOP, 0);
    repeat (RX_DEPTH + 1) send_event(i2ctcf_pkg::OP_HOST_POP, 1'b0, 1'b0, 8'h00);
    repeat (TX_DEPTH + 1) send_event(i2ctcf_pkg::OP_HOST_PUSH, 1'b0, 1'b0, 8'($urandom));
    repeat (TX_DEPTH + 1) send_event(i2ctcf_pkg::OP_READ_BYTE, 1'b0, 1'b0, 8'h00);
  endtask

  task automatic test_count_saturation();
    // every byte popped at once, so the queue never fills and the count tops out
    bus_write(70, END_STOP, 100);
  endtask

  task automatic test_receiver_holdoff();
    // result side held for a long stretch while items keep coming
    sender_idle_pct = 0;
    stall_pct = 0;
    holdoff_left = 80;
    bus_write(30, END_STOP, 0);
  endtask

  task automatic test_random_traffic(input int n_items, input int unsigned idle_pct,
                                     input int unsigned stall_chance);
    int stop_at;
    int unsigned pick;
    int nbytes;
    xfer_end_t tail;
    sender_idle_pct = idle_pct;
    stall_pct = stall_chance;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (!tgt_enabled && pick < 90) begin
        send_event(i2ctcf_pkg::OP_ENABLE_CTL, 1'($urandom), 1'($urandom),
                   8'($urandom) | 8'h01);
      end else if (tgt_busy && pick < 60) begin
        // host answers a read command, sometimes overfilling the reply queue
        nbytes = ($urandom_range(9) == 0) ? TX_DEPTH + 2 : $urandom_range(1, 8);
        repeat (nbytes) send_event(i2ctcf_pkg::OP_HOST_PUSH, 1'b0, 1'b0, 8'($urandom));
        if ($urandom_range(3) == 0)
          send_event(i2ctcf_pkg::OP_READ_BYTE, 1'b0, 1'b0, 8'h00);
        send_event(i2ctcf_pkg::OP_HOST_DONE, 1'b0, 1'b0, 8'($urandom));
        if ($urandom_range(1) == 1) bus_read(1'b0, $urandom_range(0, nbytes + 1));
      end else if (pick < 75) begin
        nbytes = ($urandom_range(9) == 0) ? $urandom_range(3, 40) : $urandom_range(0, 6);
        case ($urandom_range(2))
          0:       tail = END_STOP;
          1:       tail = END_RESTART_WRITE;
          default: tail = END_READBACK;
        endcase
        bus_write(nbytes, tail, 30);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 6))
          send_event(i2ctcf_pkg::OP_HOST_POP, 1'b0, 1'b0, 8'($urandom));
      end else begin
        // noise: any event with any field values
        send_event(3'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_disabled_block();
    test_command_cases();
    test_queue_limits();
    test_count_saturation();
    test_receiver_holdoff();
    test_random_traffic(170, 0, 0);
    test_random_traffic(170, 66, 0);
    test_random_traffic(170, 0, 66);
    test_random_traffic(170, 8, 8);
    sender_idle_pct = 0;
    stall_pct = 0;
    evt_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d host commands predicted",
             items_sent, results_checked, commands_seen);
    $display("stopped block, busy handling, full queues, count saturation, %s",
             "idle and stall mixes and a long result hold-off exercised");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/i2ctcf_pkg.sv
src/i2ctcf_fifo.sv
src/i2c_target_command_fifo_front_core.sv
tb/i2c_target_command_fifo_front_core_tb.sv
